[src/b32td_pkg.sv]
// package for the base32 text decoder: symbol table, status codes and shared types
package b32td_pkg;

   localparam logic [6:0] SYM_INVALID = 7'h7f;
   localparam logic [6:0] SYM_SKIP    = 7'h7e;

   localparam logic [1:0] ST_DATA  = 2'd0;
   localparam logic [1:0] ST_END   = 2'd1;
   localparam logic [1:0] ST_ERROR = 2'd2;

   localparam int unsigned ACC_WIDTH = 40;

   typedef struct packed {
      logic [2:0]           count;
      logic [ACC_WIDTH-1:0] bytes;
      logic                 has_byte;
      logic [1:0]           status;
   } burst_type;

   function automatic logic [6:0] char_map(input logic [7:0] ch);
      logic [7:0] lc;
      logic [6:0] v;
      if (ch >= 8'h41 && ch <= 8'h5a) begin
         lc = ch | 8'h20;
      end else begin
         lc = ch;
      end
      priority if (lc == 8'h30) begin
         v = 7'd0;
      end else if (lc >= 8'h32 && lc <= 8'h39) begin
         v = 7'(lc - 8'h32 + 8'd1);
      end else if (lc >= 8'h61 && lc <= 8'h68) begin
         v = 7'(lc - 8'h61 + 8'd9);
      end else if (lc == 8'h6a || lc == 8'h6b) begin
         v = 7'(lc - 8'h6a + 8'd17);
      end else if (lc == 8'h6d || lc == 8'h6e) begin
         v = 7'(lc - 8'h6d + 8'd19);
      end else if (lc == 8'h6f) begin
         v = 7'd0;
      end else if (lc >= 8'h70 && lc <= 8'h7a) begin
         v = 7'(lc - 8'h70 + 8'd21);
      end else if (ch == 8'h09 || ch == 8'h0a || ch == 8'h0d || ch == 8'h20 ||
                   ch == 8'h2d) begin
         v = SYM_SKIP;
      end else begin
         v = SYM_INVALID;
      end
      return v;
   endfunction

   function automatic logic [2:0] bytes_for_count(input logic [2:0] c);
      logic [2:0] n;
      unique case (c)
         3'd0: n = 3'd0;
         3'd1: n = 3'd0;
         3'd2: n = 3'd1;
         3'd3: n = 3'd1;
         3'd4: n = 3'd2;
         3'd5: n = 3'd3;
         3'd6: n = 3'd3;
         3'd7: n = 3'd4;
         default: n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic logic [2:0] pad_for_count(input logic [2:0] c);
      logic [2:0] p;
      unique case (c)
         3'd0: p = 3'd0;
         3'd1: p = 3'd3;
         3'd2: p = 3'd2;
         3'd3: p = 3'd1;
         3'd4: p = 3'd4;
         3'd5: p = 3'd1;
         3'd6: p = 3'd2;
         3'd7: p = 3'd3;
         default: p = 3'd0;
      endcase
      return p;
   endfunction

endpackage

[src/base32_text_decoder_top.sv]
// top level of the base32 text decoder: input register, group logic and result serializer
// a character waits in the input register; its results are then loaded into the serializer
// throughput: one character per cycle; a group of five bytes gives five results, and a
// following character that causes results waits until they have drained from the port
// reset: synchronous, clears the input register, the open group and any pending results
module base32_text_decoder_top
   import b32td_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // char_code
   input  logic       req_tlast,   // stream_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // data_byte
   output logic       rsp_tlast,   // run_last
   output logic [2:0] rsp_tuser    // status[1:0], has_byte
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_char_ff;
   logic                 in_end_ff;

   logic [2:0]           out_cnt_ff, out_cnt_in;
   logic [ACC_WIDTH-1:0] out_bytes_ff, out_bytes_in;
   logic                 out_has_ff, out_has_in;
   logic [1:0]           out_stat_ff, out_stat_in;

   burst_type            burst;
   logic                 rsp_fire;
   logic                 out_free;
   logic                 advance;
   logic                 load;

   b32td_group u_group (
      .clock      (clock),
      .reset      (reset),
      .char_code  (in_char_ff),
      .stream_end (in_end_ff),
      .advance    (advance),
      .burst      (burst)
   );

   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign out_free   = (out_cnt_ff == 3'd0) || (rsp_fire && out_cnt_ff == 3'd1);
   assign advance    = in_valid_ff && ((burst.count == 3'd0) || out_free);
   assign load       = advance && (burst.count != 3'd0);
   assign req_tready = !in_valid_ff || advance;

   assign rsp_tvalid = (out_cnt_ff != 3'd0);
   assign rsp_tdata  = out_has_ff ? out_bytes_ff[ACC_WIDTH-1 -: 8] : 8'd0;
   assign rsp_tlast  = (out_cnt_ff == 3'd1);
   assign rsp_tuser  = {(out_cnt_ff == 3'd1) ? out_stat_ff : ST_DATA, out_has_ff};

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_cnt_in   = out_cnt_ff;
      out_bytes_in = out_bytes_ff;
      out_has_in   = out_has_ff;
      out_stat_in  = out_stat_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      priority if (load) begin
         out_cnt_in   = burst.count;
         out_bytes_in = burst.bytes;
         out_has_in   = burst.has_byte;
         out_stat_in  = burst.status;
      end else if (rsp_fire) begin
         out_cnt_in   = out_cnt_ff - 3'd1;
         out_bytes_in = {out_bytes_ff[ACC_WIDTH-9:0], 8'd0};
      end else begin
         out_cnt_in = out_cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_cnt_ff  <= 3'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_cnt_ff  <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
      out_bytes_ff <= out_bytes_in;
      out_has_ff   <= out_has_in;
      out_stat_ff  <= out_stat_in;
   end

endmodule

[src/b32td_group.sv]
// symbol group accumulator: maps one character and forms the burst of results it causes
module b32td_group
   import b32td_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic [7:0] char_code,
   input  logic      stream_end,
   input  logic      advance,
   output burst_type burst
);

   logic [ACC_WIDTH-1:0] acc_ff, acc_in;
   logic [2:0]           cnt_ff, cnt_in;

   logic [6:0]           sym;
   logic                 is_invalid;
   logic                 is_skip;
   logic [ACC_WIDTH-1:0] shifted;
   logic [3:0]           cnt_next;
   logic [ACC_WIDTH-1:0] fin_acc;
   logic [2:0]           fin_cnt;
   logic [2:0]           fin_n;
   logic [2:0]           fin_pad;
   logic [5:0]           fin_align;
   logic [ACC_WIDTH-1:0] fin_bytes;

   always_comb begin
      sym        = char_map(char_code);
      is_invalid = (sym == SYM_INVALID);
      is_skip    = (sym == SYM_SKIP);
      shifted    = {acc_ff[ACC_WIDTH-6:0], sym[4:0]};
      cnt_next   = {1'b0, cnt_ff} + 4'd1;
      fin_acc    = is_skip ? acc_ff : shifted;
      fin_cnt    = is_skip ? cnt_ff : cnt_next[2:0];
      fin_n      = bytes_for_count(fin_cnt);
      fin_pad    = pad_for_count(fin_cnt);
      fin_align  = 6'(ACC_WIDTH) - {fin_n, 3'b000};
      fin_bytes  = (fin_acc >> fin_pad) << fin_align;

      burst.count    = 3'd0;
      burst.bytes    = '0;
      burst.has_byte = 1'b0;
      burst.status   = ST_DATA;
      acc_in         = acc_ff;
      cnt_in         = cnt_ff;

      priority if (is_invalid) begin
         burst.count  = 3'd1;
         burst.status = ST_ERROR;
         acc_in       = '0;
         cnt_in       = 3'd0;
      end else if (is_skip && !stream_end) begin
         acc_in = acc_ff;
      end else if (!is_skip && cnt_next[3]) begin
         burst.count    = 3'd5;
         burst.bytes    = shifted;
         burst.has_byte = 1'b1;
         burst.status   = stream_end ? ST_END : ST_DATA;
         acc_in         = '0;
         cnt_in         = 3'd0;
      end else if (stream_end) begin
         acc_in = '0;
         cnt_in = 3'd0;
         burst.status = ST_END;
         if (fin_n == 3'd0) begin
            burst.count = 3'd1;
         end else begin
            burst.count    = fin_n;
            burst.bytes    = fin_bytes;
            burst.has_byte = 1'b1;
         end
      end else begin
         acc_in = shifted;
         cnt_in = cnt_next[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= 3'd0;
      end else if (advance) begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
